@@ design/bounded_ratio_min_select_macros.svh @@
// Assertion macros used by the back end of the bounded ratio select design.
// Expects signals named clock and reset in the module that uses them.
`ifndef BOUNDED_RATIO_MIN_SELECT_MACROS_SVH
`define BOUNDED_RATIO_MIN_SELECT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define BRMS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define BRMS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/brms_pkg.sv @@
// Package for the bounded ratio select block: payload types, codes and
// double-precision helper functions. No dependencies.
package brms_pkg;

   localparam int BRMS_MAX_ENTRIES = 4096;
   localparam int BRMS_QUEUE_DEPTH = 4;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_ENTRY = 1'b1;

   localparam logic [1:0] CSR_DIRECTION_MODE = 2'd0;
   localparam logic [1:0] CSR_ZERO_TOL       = 2'd1;
   localparam logic [1:0] CSR_DELTA_TOL      = 2'd2;
   localparam logic [1:0] CSR_INFINITY_VALUE = 2'd3;

   localparam logic [11:0] EXP_OVERFLOW = 12'd2047;

   typedef struct packed {
      logic        command;
      logic        last;
      logic [11:0] entry_index;
      logic [63:0] update_value;
      logic [63:0] current_value;
      logic [63:0] lower_bound;
      logic [63:0] upper_bound;
      logic [63:0] start_limit;
      logic [63:0] start_abs;
   } brms_req_type;

   typedef struct packed {
      logic        found;
      logic [11:0] selected_index;
      logic [63:0] step_value;
      logic [63:0] largest_magnitude;
   } brms_rsp_type;

   typedef enum logic [1:0] {
      KIND_START,
      KIND_SKIP,
      KIND_ACTIVE
   } brms_kind_type;

   // Classified item between the front and the back.
   typedef struct packed {
      brms_kind_type kind;
      logic          last;
      logic          use_upper;
      logic          bound_ok;
      logic [11:0]   entry_index;
      logic [63:0]   update_value;
      logic [63:0]   current_value;
      logic [63:0]   bound_value;  // start_limit on a start item
      logic [63:0]   magnitude;    // start_abs on a start item
   } brms_item_type;

   typedef struct packed {
      logic        direction_mode;
      logic [63:0] delta_tol;
   } brms_cfg_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SUB_WAIT,
      BK_NUM_WAIT,
      BK_DIV_WAIT,
      BK_EMIT
   } brms_back_state_type;

   typedef enum logic [2:0] {
      FA_IDLE,
      FA_ALIGN,
      FA_ADD,
      FA_NORM,
      FA_ROUND
   } brms_fa_state_type;

   typedef enum logic [2:0] {
      FD_IDLE,
      FD_NORM,
      FD_ITER,
      FD_DENORM,
      FD_ROUND
   } brms_fd_state_type;

   function automatic logic fp_is_nan(input logic [63:0] x);
      return (&x[62:52]) && (|x[51:0]);
   endfunction

   function automatic logic fp_is_inf(input logic [63:0] x);
      return (&x[62:52]) && !(|x[51:0]);
   endfunction

   function automatic logic fp_is_zero(input logic [63:0] x);
      return !(|x[62:0]);
   endfunction

   function automatic logic [63:0] fp_neg(input logic [63:0] x);
      return {~x[63], x[62:0]};
   endfunction

   // a < b with IEEE semantics: false on NaN, +0 equals -0.
   function automatic logic fp_lt(input logic [63:0] a, input logic [63:0] b);
      logic res;
      if (fp_is_nan(a) || fp_is_nan(b) || (fp_is_zero(a) && fp_is_zero(b))) begin
         res = 1'b0;
      end else if (a[63] != b[63]) begin
         res = a[63];
      end else if (a[63]) begin
         res = a[62:0] > b[62:0];
      end else begin
         res = a[62:0] < b[62:0];
      end
      return res;
   endfunction

   // Right shift keeping every lost bit in the sticky position.
   function automatic logic [55:0] fp_shr_sticky(input logic [55:0] v,
                                                 input logic [12:0] amt);
      logic [55:0] mask;
      logic [55:0] res;
      mask = ~({56{1'b1}} << amt[5:0]);
      if (amt >= 13'd56) begin
         res = {55'b0, |v};
      end else begin
         res    = v >> amt[5:0];
         res[0] = res[0] | (|(v & mask));
      end
      return res;
   endfunction

   // Round to nearest even and pack. s holds 53 mantissa bits, guard, round,
   // sticky; e is the biased exponent with subnormals at 1.
   function automatic logic [63:0] fp_round_pack(input logic sign,
                                                 input logic [11:0] e,
                                                 input logic [55:0] s);
      logic        inc;
      logic [53:0] mr;
      logic [11:0] e2;
      logic [63:0] res;
      inc = s[2] & (s[1] | s[0] | s[3]);
      mr  = {1'b0, s[55:3]} + {53'b0, inc};
      e2  = e;
      if (mr[53]) begin
         mr = mr >> 1;
         e2 = e + 12'd1;
      end
      if (e2 >= EXP_OVERFLOW) begin
         res = {sign, 11'h7FF, 52'b0};
      end else if (mr[52]) begin
         res = {sign, e2[10:0], mr[51:0]};
      end else begin
         res = {sign, 11'b0, mr[51:0]};
      end
      return res;
   endfunction

endpackage

@@ design/bounded_ratio_min_select.sv @@
// Top level of the bounded ratio select block: front end, item queue and
// back end. Depends on brms_pkg, brms_front, brms_fifo and brms_back.
//
//   channel   handshake        payload         notes
//   req       push / full      req_data        one item accepted per cycle while not full
//   rsp       empty / pop      rsp_data        one result per item with last set
//   csr       csr_wr_en        csr_index/wdata direction, zero tol, delta tol, infinity
//
// The front classifies each item in the cycle it is accepted and writes it to a
// QUEUE_DEPTH-entry queue; push is refused only while that queue is full.
// Start, skipped and absent-bound items are handled in BK_IDLE, with BK_EMIT after it on last.
// An entry that forms a ratio runs BK_SUB_WAIT, then BK_NUM_WAIT unless the bound is
// already passed, then BK_DIV_WAIT: one or two passes through the multi-cycle adder
// and one through the divider, whose one-quotient-bit-per-cycle loop has 55 steps;
// subnormal operands add normalization steps, and NaN, infinite or zero operands
// finish a unit straight from its idle state.
// Reset (synchronous, active high) clears configuration, the selection state,
// the item queue and the result valid flag. A waiting result holds the back only
// when the next result is ready to be emitted.
module bounded_ratio_min_select
   import brms_pkg::*;
#(
   parameter int MAX_ENTRIES = BRMS_MAX_ENTRIES,
   parameter int QUEUE_DEPTH = BRMS_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_wdata,
   input  logic         push,
   output logic         full,
   input  brms_req_type req_data,
   output logic         empty,
   input  logic         pop,
   output brms_rsp_type rsp_data
);

   brms_item_type q_in_item, q_head;
   brms_cfg_type  cfg;
   logic          q_push, q_full, q_pop, q_empty;
   logic          rsp_valid;

   // classify and transfer into the queue
   brms_front #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_push  (push),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (q_in_item),
      .cfg       (cfg)
   );

   // decouple the front from the long arithmetic in the back
   brms_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .data_in  (q_in_item),
      .full     (q_full),
      .pop      (q_pop),
      .data_out (q_head),
      .empty    (q_empty)
   );

   // run the ratio arithmetic and hold the result until it is taken
   brms_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_pop   (pop)
   );

   assign full  = q_full;
   assign empty = !rsp_valid;

endmodule

@@ design/brms_fifo.sv @@
// Short queue of classified items between front and back.
// Depends on brms_pkg.
module brms_fifo
   import brms_pkg::*;
#(
   parameter int DEPTH = BRMS_QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  brms_item_type data_in,
   output logic          full,
   input  logic          pop,
   output brms_item_type data_out,
   output logic          empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   brms_item_type      slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

@@ design/brms_front.sv @@
// Front end: configuration registers and per-item classification.
// Depends on brms_pkg.
module brms_front
   import brms_pkg::*;
#(
   parameter int MAX_ENTRIES = BRMS_MAX_ENTRIES
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [1:0]    csr_index,
   input  logic [63:0]   csr_wdata,
   input  logic          req_push,
   input  brms_req_type  req_data,
   input  logic          q_full,
   output logic          q_push,
   output brms_item_type q_item,
   output brms_cfg_type  cfg
);

   logic        direction_mode_ff;
   logic [63:0] zero_tol_ff;
   logic [63:0] delta_tol_ff;
   logic [63:0] infinity_value_ff;

   logic positive, negative, nonzero, in_range, active, use_upper;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_mode_ff <= 1'b0;
         zero_tol_ff       <= '0;
         delta_tol_ff      <= '0;
         infinity_value_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DIRECTION_MODE: direction_mode_ff <= csr_wdata[0];
            CSR_ZERO_TOL:       zero_tol_ff       <= csr_wdata;
            CSR_DELTA_TOL:      delta_tol_ff      <= csr_wdata;
            CSR_INFINITY_VALUE: infinity_value_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg.direction_mode = direction_mode_ff;
   assign cfg.delta_tol      = delta_tol_ff;

   assign q_push = req_push && !q_full;

   always_comb begin
      positive  = fp_lt(zero_tol_ff, req_data.update_value);
      negative  = fp_lt(req_data.update_value, fp_neg(zero_tol_ff));
      nonzero   = !fp_is_zero(req_data.update_value);
      in_range  = 32'(req_data.entry_index) < 32'(MAX_ENTRIES);
      active    = nonzero && (positive || negative) && in_range;
      use_upper = positive != direction_mode_ff;

      q_item.last          = req_data.last;
      q_item.use_upper     = use_upper;
      q_item.entry_index   = req_data.entry_index;
      q_item.update_value  = req_data.update_value;
      q_item.current_value = req_data.current_value;
      q_item.bound_ok      = use_upper ?
                             fp_lt(req_data.upper_bound, infinity_value_ff) :
                             fp_lt(fp_neg(infinity_value_ff), req_data.lower_bound);
      if (req_data.command == CMD_START) begin
         q_item.kind        = KIND_START;
         q_item.bound_value = req_data.start_limit;
         q_item.magnitude   = req_data.start_abs;
      end else begin
         q_item.kind        = active ? KIND_ACTIVE : KIND_SKIP;
         q_item.bound_value = use_upper ? req_data.upper_bound : req_data.lower_bound;
         q_item.magnitude   = positive ? req_data.update_value :
                                         fp_neg(req_data.update_value);
      end
   end

endmodule

@@ design/brms_fp_add.sv @@
// Multi-cycle double-precision adder, round to nearest even.
// Depends on brms_pkg.
module brms_fp_add
   import brms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        done,
   output logic [63:0] result
);

   brms_fa_state_type state_ff, state_in;
   logic        done_ff, done_in;
   logic [63:0] result_ff, result_in;
   logic        sign_big_ff, sign_big_in;
   logic        sign_small_ff, sign_small_in;
   logic [11:0] e_big_ff, e_big_in;
   logic [11:0] e_small_ff, e_small_in;
   logic [55:0] m_big_ff, m_big_in;
   logic [55:0] m_small_ff, m_small_in;
   logic [11:0] e_ff, e_in;
   logic [55:0] s_ff, s_in;

   logic        a_big, any_nan;
   logic [63:0] big, lesser;
   logic [56:0] sum;
   logic [11:0] diff;

   always_comb begin
      state_in      = state_ff;
      done_in       = 1'b0;
      result_in     = result_ff;
      sign_big_in   = sign_big_ff;
      sign_small_in = sign_small_ff;
      e_big_in      = e_big_ff;
      e_small_in    = e_small_ff;
      m_big_in      = m_big_ff;
      m_small_in    = m_small_ff;
      e_in          = e_ff;
      s_in          = s_ff;
      a_big         = a[62:0] >= b[62:0];
      big           = a_big ? a : b;
      lesser        = a_big ? b : a;
      any_nan       = fp_is_nan(a) || fp_is_nan(b) ||
                      (fp_is_inf(a) && fp_is_inf(b) && (a[63] != b[63]));
      diff          = e_big_ff - e_small_ff;
      sum           = (sign_big_ff == sign_small_ff) ?
                      {1'b0, m_big_ff} + {1'b0, m_small_ff} :
                      {1'b0, m_big_ff} - {1'b0, m_small_ff};

      unique case (state_ff)
         FA_IDLE: begin
            if (start) begin
               if (any_nan) begin
                  result_in = {1'b0, 11'h7FF, 1'b1, 51'b0};
                  done_in   = 1'b1;
               end else if (fp_is_inf(a) || fp_is_inf(b)) begin
                  result_in = fp_is_inf(a) ? a : b;
                  done_in   = 1'b1;
               end else begin
                  sign_big_in   = big[63];
                  sign_small_in = lesser[63];
                  e_big_in      = {1'b0, (big[62:52] == '0) ? 11'd1 : big[62:52]};
                  e_small_in    = {1'b0, (lesser[62:52] == '0) ? 11'd1 : lesser[62:52]};
                  m_big_in      = {|big[62:52], big[51:0], 3'b0};
                  m_small_in    = {|lesser[62:52], lesser[51:0], 3'b0};
                  state_in      = FA_ALIGN;
               end
            end
         end
         FA_ALIGN: begin
            m_small_in = fp_shr_sticky(m_small_ff, {1'b0, diff});
            state_in   = FA_ADD;
         end
         FA_ADD: begin
            e_in = e_big_ff;
            if (sum == '0) begin
               // exact cancellation gives +0; two like-signed zeros keep the sign
               result_in = {(sign_big_ff == sign_small_ff) ? sign_big_ff : 1'b0, 63'b0};
               done_in   = 1'b1;
               state_in  = FA_IDLE;
            end else if (sum[56]) begin
               s_in     = {sum[56:2], sum[1] | sum[0]};
               e_in     = e_big_ff + 12'd1;
               state_in = FA_ROUND;
            end else begin
               s_in     = sum[55:0];
               state_in = FA_NORM;
            end
         end
         FA_NORM: begin
            if (s_ff[55] || (e_ff == 12'd1)) begin
               state_in = FA_ROUND;
            end else if ((s_ff[55:48] == '0) && (e_ff > 12'd8)) begin
               s_in = s_ff << 8;
               e_in = e_ff - 12'd8;
            end else begin
               s_in = s_ff << 1;
               e_in = e_ff - 12'd1;
            end
         end
         FA_ROUND: begin
            result_in = fp_round_pack(sign_big_ff, e_ff, s_ff);
            done_in   = 1'b1;
            state_in  = FA_IDLE;
         end
         default: state_in = FA_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FA_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff     <= result_in;
      sign_big_ff   <= sign_big_in;
      sign_small_ff <= sign_small_in;
      e_big_ff      <= e_big_in;
      e_small_ff    <= e_small_in;
      m_big_ff      <= m_big_in;
      m_small_ff    <= m_small_in;
      e_ff          <= e_in;
      s_ff          <= s_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

@@ design/brms_fp_div.sv @@
// Iterative double-precision divider, one quotient bit per cycle,
// round to nearest even. Depends on brms_pkg.
module brms_fp_div
   import brms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        done,
   output logic [63:0] result
);

   localparam int QUO_BITS = 55;

   brms_fd_state_type state_ff, state_in;
   logic               done_ff, done_in;
   logic [63:0]        result_ff, result_in;
   logic               sign_ff, sign_in;
   logic [52:0]        ma_ff, ma_in;
   logic [52:0]        mb_ff, mb_in;
   logic signed [13:0] ea_ff, ea_in;
   logic signed [13:0] eb_ff, eb_in;
   logic signed [13:0] exp_ff, exp_in;
   logic [53:0]        rem_ff, rem_in;
   logic [54:0]        quo_ff, quo_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [11:0]        e_ff, e_in;
   logic [55:0]        s_ff, s_in;

   logic               ge, a_less;
   logic [53:0]        rem_sub;
   logic signed [13:0] shamt;
   logic [55:0]        s_full;

   always_comb begin
      state_in  = state_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      sign_in   = sign_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      ea_in     = ea_ff;
      eb_in     = eb_ff;
      exp_in    = exp_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      e_in      = e_ff;
      s_in      = s_ff;
      ge        = rem_ff >= {1'b0, mb_ff};
      rem_sub   = rem_ff - {1'b0, mb_ff};
      a_less    = ma_ff < mb_ff;
      shamt     = 14'sd1 - exp_ff;
      s_full    = {quo_ff, |rem_ff};

      unique case (state_ff)
         FD_IDLE: begin
            if (start) begin
               sign_in = a[63] ^ b[63];
               if (fp_is_nan(a) || fp_is_nan(b) || (fp_is_inf(a) && fp_is_inf(b)) ||
                   (fp_is_zero(a) && fp_is_zero(b))) begin
                  result_in = {1'b0, 11'h7FF, 1'b1, 51'b0};
                  done_in   = 1'b1;
               end else if (fp_is_inf(a) || fp_is_zero(b)) begin
                  result_in = {a[63] ^ b[63], 11'h7FF, 52'b0};
                  done_in   = 1'b1;
               end else if (fp_is_inf(b) || fp_is_zero(a)) begin
                  result_in = {a[63] ^ b[63], 63'b0};
                  done_in   = 1'b1;
               end else begin
                  ma_in    = {|a[62:52], a[51:0]};
                  mb_in    = {|b[62:52], b[51:0]};
                  ea_in    = {3'b0, (a[62:52] == '0) ? 11'd1 : a[62:52]};
                  eb_in    = {3'b0, (b[62:52] == '0) ? 11'd1 : b[62:52]};
                  state_in = FD_NORM;
               end
            end
         end
         FD_NORM: begin
            // bring subnormal operands to a leading one, then line up the
            // dividend so the quotient lands in [1, 2)
            if (ma_ff[52] && mb_ff[52]) begin
               rem_in   = a_less ? {ma_ff, 1'b0} : {1'b0, ma_ff};
               exp_in   = ea_ff - eb_ff + 14'sd1023 - (a_less ? 14'sd1 : 14'sd0);
               cnt_in   = 6'(QUO_BITS - 1);
               state_in = FD_ITER;
            end else begin
               if (!ma_ff[52]) begin
                  ma_in = ma_ff << 1;
                  ea_in = ea_ff - 14'sd1;
               end
               if (!mb_ff[52]) begin
                  mb_in = mb_ff << 1;
                  eb_in = eb_ff - 14'sd1;
               end
            end
         end
         FD_ITER: begin
            quo_in = {quo_ff[53:0], ge};
            rem_in = ge ? {rem_sub[52:0], 1'b0} : {rem_ff[52:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               state_in = FD_DENORM;
            end
         end
         FD_DENORM: begin
            if (exp_ff >= 14'sd2047) begin
               result_in = {sign_ff, 11'h7FF, 52'b0};
               done_in   = 1'b1;
               state_in  = FD_IDLE;
            end else if (exp_ff <= 14'sd0) begin
               s_in     = fp_shr_sticky(s_full, shamt[12:0]);
               e_in     = 12'd1;
               state_in = FD_ROUND;
            end else begin
               s_in     = s_full;
               e_in     = exp_ff[11:0];
               state_in = FD_ROUND;
            end
         end
         FD_ROUND: begin
            result_in = fp_round_pack(sign_ff, e_ff, s_ff);
            done_in   = 1'b1;
            state_in  = FD_IDLE;
         end
         default: state_in = FD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
      sign_ff   <= sign_in;
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      ea_ff     <= ea_in;
      eb_ff     <= eb_in;
      exp_ff    <= exp_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      e_ff      <= e_in;
      s_ff      <= s_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

@@ design/brms_back.sv @@
// Back end: sequences the ratio arithmetic per item, keeps the running
// selection and holds the result register. Depends on brms_pkg,
// brms_fp_add, brms_fp_div and the assertion macros.
`include "bounded_ratio_min_select_macros.svh"

module brms_back
   import brms_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  brms_cfg_type  cfg,
   input  logic          q_empty,
   input  brms_item_type q_head,
   output logic          q_pop,
   output logic          rsp_valid,
   output brms_rsp_type  rsp_data,
   input  logic          rsp_pop
);

   brms_back_state_type state_ff, state_in;
   brms_item_type item_ff, item_in;
   logic [63:0]   best_ratio_ff, best_ratio_in;
   logic [11:0]   best_index_ff, best_index_in;
   logic          have_sel_ff, have_sel_in;
   logic [63:0]   max_mag_ff, max_mag_in;
   logic          rsp_valid_ff, rsp_valid_in;
   brms_rsp_type  rsp_data_ff, rsp_data_in;

   logic          add_go, add_done;
   logic [63:0]   add_a, add_b, add_res;
   logic          div_go, div_done;
   logic [63:0]   div_a, div_b, div_res;
   logic          y_le_zero, y_ge_zero, better;
   brms_back_state_type after_item;

   brms_fp_add u_add (
      .clock  (clock),
      .reset  (reset),
      .start  (add_go),
      .a      (add_a),
      .b      (add_b),
      .done   (add_done),
      .result (add_res)
   );

   brms_fp_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_go),
      .a      (div_a),
      .b      (div_b),
      .done   (div_done),
      .result (div_res)
   );

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      best_ratio_in = best_ratio_ff;
      best_index_in = best_index_ff;
      have_sel_in   = have_sel_ff;
      max_mag_in    = max_mag_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_pop;
      rsp_data_in   = rsp_data_ff;
      q_pop         = 1'b0;
      add_go        = 1'b0;
      add_a         = '0;
      add_b         = '0;
      div_go        = 1'b0;
      div_a         = '0;
      div_b         = '0;
      y_le_zero     = !fp_is_nan(add_res) && (add_res[63] || fp_is_zero(add_res));
      y_ge_zero     = !fp_is_nan(add_res) && (!add_res[63] || fp_is_zero(add_res));
      better        = cfg.direction_mode ? fp_lt(best_ratio_ff, div_res) :
                                           fp_lt(div_res, best_ratio_ff);
      after_item    = item_ff.last ? BK_EMIT : BK_IDLE;

      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               item_in = q_head;
               unique case (q_head.kind)
                  KIND_START: begin
                     best_ratio_in = q_head.bound_value;
                     max_mag_in    = q_head.magnitude;
                     have_sel_in   = 1'b0;
                     best_index_in = '0;
                     state_in      = q_head.last ? BK_EMIT : BK_IDLE;
                  end
                  KIND_ACTIVE: begin
                     if (fp_lt(max_mag_ff, q_head.magnitude)) begin
                        max_mag_in = q_head.magnitude;
                     end
                     if (q_head.bound_ok) begin
                        // distance to the bound: bound - current
                        add_go   = 1'b1;
                        add_a    = q_head.bound_value;
                        add_b    = fp_neg(q_head.current_value);
                        state_in = BK_SUB_WAIT;
                     end else begin
                        state_in = q_head.last ? BK_EMIT : BK_IDLE;
                     end
                  end
                  default: begin
                     state_in = q_head.last ? BK_EMIT : BK_IDLE;
                  end
               endcase
            end
         end
         BK_SUB_WAIT: begin
            if (add_done) begin
               // a bound already passed leaves only the tolerance term
               if (item_ff.use_upper ? y_le_zero : y_ge_zero) begin
                  div_go   = 1'b1;
                  div_a    = item_ff.use_upper ? cfg.delta_tol : fp_neg(cfg.delta_tol);
                  div_b    = item_ff.update_value;
                  state_in = BK_DIV_WAIT;
               end else begin
                  add_go   = 1'b1;
                  add_a    = add_res;
                  add_b    = item_ff.use_upper ? cfg.delta_tol : fp_neg(cfg.delta_tol);
                  state_in = BK_NUM_WAIT;
               end
            end
         end
         BK_NUM_WAIT: begin
            if (add_done) begin
               div_go   = 1'b1;
               div_a    = add_res;
               div_b    = item_ff.update_value;
               state_in = BK_DIV_WAIT;
            end
         end
         BK_DIV_WAIT: begin
            if (div_done) begin
               if (better) begin
                  best_ratio_in = div_res;
                  best_index_in = item_ff.entry_index;
                  have_sel_in   = 1'b1;
               end
               state_in = after_item;
            end
         end
         BK_EMIT: begin
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_valid_in                  = 1'b1;
               rsp_data_in.found             = have_sel_ff;
               rsp_data_in.selected_index    = have_sel_ff ? best_index_ff : '0;
               rsp_data_in.step_value        = best_ratio_ff;
               rsp_data_in.largest_magnitude = max_mag_ff;
               state_in                      = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         best_ratio_ff <= '0;
         best_index_ff <= '0;
         have_sel_ff   <= 1'b0;
         max_mag_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         best_ratio_ff <= best_ratio_in;
         best_index_ff <= best_index_in;
         have_sel_ff   <= have_sel_in;
         max_mag_ff    <= max_mag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `BRMS_ASSERT_IMP(a_index_needs_sel, !have_sel_ff, best_index_ff == '0, "index set without selection")
   `BRMS_ASSERT_IMP(a_add_done_waited, add_done, (state_ff == BK_SUB_WAIT) || (state_ff == BK_NUM_WAIT), "adder finished while not awaited")
   `BRMS_ASSERT_IMP(a_div_done_waited, div_done, state_ff == BK_DIV_WAIT, "divider finished while not awaited")
   `BRMS_ASSERT_IMP(a_rsp_from_emit, $rose(rsp_valid_ff), $past(state_ff == BK_EMIT), "result appeared outside emit")
   `BRMS_ASSERT_NXT(a_units_exclusive, add_go || div_go, state_ff != BK_IDLE, "arithmetic started without leaving idle")

endmodule
